// ===== sv/rfpb_pkg.sv =====
package rfpb_pkg;

   localparam int TYPE_W = 7;
   localparam int SSRC_W = 32;
   localparam int SEQ_W  = 16;
   localparam int TIME_W = 32;
   localparam int LEN_W  = 14;
   localparam int WORD_W = 32;

   localparam logic [7:0] FILL_BYTE = 8'hd5;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_BYTE  = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_WORD   = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_DROP   = 2'd2,
      ST_RESET  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_TYPE = 2'd0,
      CSR_SSRC = 2'd1,
      CSR_SEQ  = 2'd2,
      CSR_TS   = 2'd3
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic close;
      logic pad_write;
      logic byte_write;
      logic eval;
      logic check;
      logic load_status;
      logic frame_begin;
      logic rd_issue;
      logic load_word;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic accepting;
      logic aligned;
      logic last_byte;
      logic lane_end;
      logic word_last;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic [SSRC_W-1:0] frame_source;
      logic [TIME_W-1:0] frame_time;
      logic [SEQ_W-1:0]  frame_seq;
      logic [TYPE_W-1:0] frame_type;
      status_type        status;
      logic              silence;
      logic              last;
   } result_type;

endpackage

// ===== sv/rtp_frame_playout_buffer.sv =====
// RTP frame playout buffer.
// req channel: one word per command. tuser carries the action (payload start,
// payload byte, frame request); tdata carries ssrc, length and data byte.
// A payload start returns one status word on rsp (accepted, dropped for
// overflow, or accepted after a source change emptied the buffer). Payload
// bytes return nothing. A frame request returns (FRAME_BYTES+3)/4 frame words
// stamped with payload type, sequence, timestamp and ssrc; tlast marks the
// final word of a frame and every status word.
// A payload start writes fill bytes when it closes an open payload; the
// final byte of a payload likewise adds fill bytes. A frame request reads
// its bytes one at a time through the single byte-wide read port of the
// buffer memory.
// The csr port loads payload type, ssrc, and the sequence and timestamp
// counters; write it only while the block is idle.
// Reset empties the buffer and clears the counters; memory contents are not
// cleared and need no clearing pass. A stalled rsp holds its word in the
// output register and the next command waits in the controller.
module rtp_frame_playout_buffer
   import rfpb_pkg::*;
#(
   parameter int BUFFER_BYTES = 8192,
   parameter int FRAME_BYTES  = 160
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,  // packet_ssrc, payload_length, data_byte, zero pad
   input  logic [1:0]   req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // frame_type, frame_seq, frame_time, frame_source,
                                    // data_word, zero pad
   output logic [2:0]   rsp_tuser,  // status, silence
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   logic [TYPE_W-1:0] pt_code_ff, pt_code_in;
   logic [SSRC_W-1:0] stream_ssrc_ff, stream_ssrc_in;
   logic              seq_load;
   logic              time_load;
   cmd_type           cmd;
   stat_type          stat;
   result_type        result;
   csr_index_type     csr_index;

   assign csr_index = csr_index_type'(csr_addr);

   always_comb begin
      pt_code_in     = pt_code_ff;
      stream_ssrc_in = stream_ssrc_ff;
      seq_load       = 1'b0;
      time_load      = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TYPE: pt_code_in     = csr_wdata[TYPE_W-1:0];
            CSR_SSRC: stream_ssrc_in = csr_wdata[SSRC_W-1:0];
            CSR_SEQ:  seq_load       = 1'b1;
            CSR_TS:   time_load      = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_code_ff     <= TYPE_W'(8);
         stream_ssrc_ff <= '0;
      end else begin
         pt_code_ff     <= pt_code_in;
         stream_ssrc_ff <= stream_ssrc_in;
      end
   end

   rfpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (action_type'(req_tuser)),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rfpb_dp #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .FRAME_BYTES  (FRAME_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_packet_ssrc    (req_tdata[31:0]),
      .req_payload_length (req_tdata[45:32]),
      .req_data_byte      (req_tdata[53:46]),
      .seq_load           (seq_load),
      .seq_value          (csr_wdata[SEQ_W-1:0]),
      .time_load          (time_load),
      .time_value         (csr_wdata[TIME_W-1:0]),
      .pt_code            (pt_code_ff),
      .stream_ssrc        (stream_ssrc_ff),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_result         (result)
   );

   assign rsp_tdata = {1'b0, result.data_word, result.frame_source, result.frame_time,
                       result.frame_seq, result.frame_type};
   assign rsp_tuser = {result.silence, result.status};
   assign rsp_tlast = result.last;

endmodule

// ===== sv/rfpb_ctrl.sv =====
module rfpb_ctrl
   import rfpb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  action_type req_action,
   output logic       req_tready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_BYTE,
      S_PAD_IDLE,
      S_PAD_START,
      S_EVAL,
      S_CHECK,
      S_STATUS,
      S_FRAME,
      S_FR_RD,
      S_FR_FIN,
      S_FR_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               unique case (req_action)
                  ACT_START: begin
                     cmd.close = 1'b1;
                     state_in  = S_PAD_START;
                  end
                  ACT_BYTE:  state_in = stat.accepting ? S_BYTE : S_IDLE;
                  ACT_FRAME: state_in = S_FRAME;
                  ACT_NONE:  state_in = S_IDLE;
               endcase
            end
         end
         S_BYTE: begin
            cmd.byte_write = 1'b1;
            state_in = stat.last_byte ? S_PAD_IDLE : S_IDLE;
         end
         S_PAD_IDLE: begin
            if (stat.aligned) state_in = S_IDLE;
            else cmd.pad_write = 1'b1;
         end
         S_PAD_START: begin
            if (stat.aligned) state_in = S_EVAL;
            else cmd.pad_write = 1'b1;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_STATUS;
         end
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.load_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_FRAME: begin
            cmd.frame_begin = 1'b1;
            state_in        = S_FR_RD;
         end
         S_FR_RD: begin
            cmd.rd_issue = 1'b1;
            if (stat.lane_end) state_in = S_FR_FIN;
         end
         // last byte of the word lands in the word register here
         S_FR_FIN: state_in = S_FR_OUT;
         S_FR_OUT: begin
            if (stat.out_free) begin
               cmd.load_word = 1'b1;
               state_in = stat.word_last ? S_IDLE : S_FR_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/rfpb_dp.sv =====
module rfpb_dp
   import rfpb_pkg::*;
#(
   parameter int BUFFER_BYTES = 8192,
   parameter int FRAME_BYTES  = 160
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [SSRC_W-1:0] req_packet_ssrc,
   input  logic [LEN_W-1:0]  req_payload_length,
   input  logic [7:0]        req_data_byte,
   input  logic              seq_load,
   input  logic [SEQ_W-1:0]  seq_value,
   input  logic              time_load,
   input  logic [TIME_W-1:0] time_value,
   input  logic [TYPE_W-1:0] pt_code,
   input  logic [SSRC_W-1:0] stream_ssrc,
   input  logic              rsp_tready,
   output logic              rsp_valid,
   output result_type        rsp_result
);

   localparam int PW          = $clog2(BUFFER_BYTES);
   localparam int OW          = $clog2(FRAME_BYTES);
   localparam int FRAME_WORDS = (FRAME_BYTES + 3) / 4;
   localparam int IW          = $clog2(4 * FRAME_WORDS + 1);
   localparam int SW          = ((PW > LEN_W) ? PW : LEN_W) + 1;
   localparam logic [IW-1:0] IDX_END   = IW'(4 * FRAME_WORDS);
   localparam logic [IW-1:0] IDX_FRAME = IW'(FRAME_BYTES);
   localparam logic [SW-1:0] LIMIT     = SW'(BUFFER_BYTES - FRAME_BYTES);
   localparam logic [PW-1:0] FRAME_P   = PW'(FRAME_BYTES);
   localparam logic [OW-1:0] OFF_LAST  = OW'(FRAME_BYTES - 1);

   logic [7:0] mem [BUFFER_BYTES];

   // buffer state
   logic [PW-1:0]     wpos_ff, wpos_in;
   logic [PW-1:0]     rpos_ff, rpos_in;
   logic [OW-1:0]     foff_ff, foff_in;
   logic [SSRC_W-1:0] src_ff, src_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic              accepting_ff, accepting_in;
   logic              out_valid_ff, out_valid_in;
   logic              pend_ff, pend_in;

   // item and frame working registers
   logic [SSRC_W-1:0] ssrc_ff, ssrc_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        byte_ff, byte_in;
   status_type        status_ff, status_in;
   logic              have_ff, have_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [1:0]        lane_ff, lane_in;
   logic              zero_ff, zero_in;
   logic [WORD_W-1:0] word_ff, word_in;
   result_type        out_ff, out_in;
   logic [7:0]        rdata_ff;

   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic [PW-1:0]     rd_addr;
   logic              have_now;
   logic              drain;

   assign rd_addr  = rpos_ff + PW'(idx_ff);
   assign have_now = (wpos_ff >= rpos_ff) && ((wpos_ff - rpos_ff) >= FRAME_P);
   assign drain    = ({1'b0, rpos_ff} + {1'b0, FRAME_P}) >= {1'b0, wpos_ff};

   assign stat.accepting = accepting_ff;
   assign stat.aligned   = (foff_ff == '0);
   assign stat.last_byte = (left_ff == LEN_W'(1));
   assign stat.lane_end  = (idx_ff[1:0] == 2'b11);
   assign stat.word_last = (idx_ff == IDX_END);
   assign stat.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      wpos_in      = wpos_ff;
      rpos_in      = rpos_ff;
      foff_in      = foff_ff;
      src_in       = src_ff;
      seq_in       = seq_ff;
      time_in      = time_ff;
      left_in      = left_ff;
      accepting_in = accepting_ff;
      out_valid_in = out_valid_ff;
      ssrc_in      = ssrc_ff;
      len_in       = len_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      have_in      = have_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      out_in       = out_ff;
      pend_in      = cmd.rd_issue;
      lane_in      = idx_ff[1:0];
      zero_in      = (idx_ff >= IDX_FRAME);
      mem_we       = 1'b0;
      mem_wdata    = FILL_BYTE;

      if (cmd.latch) begin
         ssrc_in = req_packet_ssrc;
         len_in  = req_payload_length;
         byte_in = req_data_byte;
      end

      // start closes any open payload; its stored part gets padded
      if (cmd.close) begin
         accepting_in = 1'b0;
         left_in      = '0;
      end

      if (cmd.pad_write || cmd.byte_write) begin
         mem_we    = 1'b1;
         mem_wdata = cmd.byte_write ? byte_ff : FILL_BYTE;
         wpos_in   = wpos_ff + 1'b1;
         foff_in   = (foff_ff == OFF_LAST) ? '0 : foff_ff + 1'b1;
      end

      if (cmd.byte_write) begin
         left_in = left_ff - 1'b1;
         if (left_ff == LEN_W'(1)) accepting_in = 1'b0;
      end

      if (cmd.eval) begin
         src_in    = ssrc_ff;
         status_in = ST_ACCEPT;
         // new source while data waits: empty the buffer
         if ((wpos_ff != '0) && (src_ff != ssrc_ff)) begin
            wpos_in   = '0;
            rpos_in   = '0;
            foff_in   = '0;
            status_in = ST_RESET;
         end
      end

      if (cmd.check) begin
         if ((SW'(wpos_ff) + SW'(len_ff)) > LIMIT) begin
            status_in = ST_DROP;
         end else if (len_ff != '0) begin
            accepting_in = 1'b1;
            left_in      = len_ff;
         end
      end

      if (cmd.frame_begin) begin
         seq_in  = seq_ff + 1'b1;
         time_in = time_ff + TIME_W'(FRAME_BYTES);
         have_in = have_now;
         idx_in  = '0;
      end

      if (cmd.rd_issue) idx_in = idx_ff + 1'b1;

      if (pend_ff) begin
         word_in[{lane_ff, 3'b000} +: 8] = zero_ff ? 8'h00 :
                                           (have_ff ? rdata_ff : FILL_BYTE);
      end

      if (seq_load)  seq_in  = seq_value;
      if (time_load) time_in = time_value;

      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;

      if (cmd.load_status) begin
         out_valid_in        = 1'b1;
         out_in              = '0;
         out_in.status       = status_ff;
         out_in.last         = 1'b1;
      end

      if (cmd.load_word) begin
         out_valid_in        = 1'b1;
         out_in.status       = ST_WORD;
         out_in.frame_type   = pt_code;
         out_in.frame_seq    = seq_ff;
         out_in.frame_time   = time_ff;
         out_in.frame_source = stream_ssrc;
         out_in.data_word    = word_ff;
         out_in.silence      = !have_ff;
         out_in.last         = stat.word_last;
         // advance past the frame; rewind both positions once drained
         if (stat.word_last && have_ff) begin
            rpos_in = rpos_ff + FRAME_P;
            if (drain) begin
               rpos_in = '0;
               wpos_in = '0;
               foff_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         foff_ff      <= '0;
         src_ff       <= '0;
         seq_ff       <= '0;
         time_ff      <= '0;
         left_ff      <= '0;
         accepting_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         foff_ff      <= foff_in;
         src_ff       <= src_in;
         seq_ff       <= seq_in;
         time_ff      <= time_in;
         left_ff      <= left_in;
         accepting_ff <= accepting_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ssrc_ff   <= ssrc_in;
      len_ff    <= len_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      have_ff   <= have_in;
      idx_ff    <= idx_in;
      lane_ff   <= lane_in;
      zero_ff   <= zero_in;
      word_ff   <= word_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wpos_ff] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue && have_ff) rdata_ff <= mem[rd_addr];
   end

   a_read_behind_write: assert property (@(posedge clock) disable iff (reset)
      rpos_ff <= wpos_ff)
      else $error("read position passed write position");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_status || cmd.load_word) |-> stat.out_free)
      else $error("result loaded over a pending word");

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      accepting_ff |-> (left_ff != '0))
      else $error("open payload with no bytes left");

   a_source_taken: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> (src_ff == ssrc_ff))
      else $error("buffered source not updated before length check");

endmodule
